// File: hdl/lms_pkg.sv
// Shared types, constants and the neighborhood compare function for the
// 3x3 local minimum suppressor. No dependencies.
package lms_pkg;

  localparam int PIXEL_BITS    = 16;
  localparam int ROW_BITS      = 10;
  localparam int COL_BITS      = 10;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 1;
  localparam int HEIGHT_LIMIT  = 1024;
  localparam int WIDTH_RESET   = 1024;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int FIFO_DEPTH    = 8;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  // One window column: [0] top row, [1] middle row, [2] bottom row.
  typedef pix_t  [2:0] wcol_t;
  // Window: [0] left column, [1] center column, [2] right column.
  typedef wcol_t [2:0] win_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_in;
    logic                         drain;
  } in_item_t;

  typedef struct packed {
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic                         is_minimum;
    logic [ROW_BITS-1:0]          out_row;
    logic [COL_BITS-1:0]          out_column;
    logic                         frame_last;
  } out_item_t;

  // Control that travels with an item from the accept stage to the window stage.
  typedef struct packed {
    logic                is_drain;
    logic                bank_sel;
    logic                emit_a;
    logic                emit_b;
    logic                lv_a;
    logic                rv_a;
    logic                bv_a;
    logic                lv_b;
    logic                tv;
    logic                last;
    logic [ROW_BITS-1:0] row_o;
    logic [COL_BITS-1:0] col_a;
    logic [COL_BITS-1:0] col_b;
  } stage_ctrl_t;

  // True when the middle pixel of column m is strictly below every enabled neighbor.
  function automatic logic is_local_min(input wcol_t l, input wcol_t m, input wcol_t r,
                                        input logic lv, input logic rv,
                                        input logic tv, input logic bv);
    logic ok;
    pix_t ctr;
    begin
      ctr = m[1];
      ok  = 1'b1;
      if (tv && !($signed(ctr) < $signed(m[0]))) ok = 1'b0;
      if (bv && !($signed(ctr) < $signed(m[2]))) ok = 1'b0;
      if (lv) begin
        if (!($signed(ctr) < $signed(l[1]))) ok = 1'b0;
        if (tv && !($signed(ctr) < $signed(l[0]))) ok = 1'b0;
        if (bv && !($signed(ctr) < $signed(l[2]))) ok = 1'b0;
      end
      if (rv) begin
        if (!($signed(ctr) < $signed(r[1]))) ok = 1'b0;
        if (tv && !($signed(ctr) < $signed(r[0]))) ok = 1'b0;
        if (bv && !($signed(ctr) < $signed(r[2]))) ok = 1'b0;
      end
      return ok;
    end
  endfunction

endpackage

// File: hdl/lms_line_ram.sv
// Line buffer memory: one write port and two registered read ports.
// Depends on nothing but its parameters.
module lms_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  // Reads return the contents from before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hdl/lms_window.sv
// Window stage: 3x3 window registers, neighborhood compares and result build.
// Depends on lms_pkg; fed by the accept stage and the two line buffers.
module lms_window
  import lms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        s0_valid,
  input  stage_ctrl_t s0_ctrl,
  input  pix_t        s0_pixel,
  input  pix_t        rd0_a,
  input  pix_t        rd0_b,
  input  pix_t        rd1_a,
  input  pix_t        rd1_b,
  output logic        push_a,
  output out_item_t   res_a,
  output logic        push_b,
  output out_item_t   res_b
);

  logic        s1_valid_r;
  stage_ctrl_t s1_ctrl_r;
  pix_t        s1_pixel_r;
  win_t        win_r;
  win_t        win_nxt;
  wcol_t       col_a;
  wcol_t       col_b;
  logic        min_a;
  logic        min_b;

  always_comb begin
    // The bank selected by bank_sel holds the older (upper) row.
    col_a[0] = s1_ctrl_r.bank_sel ? rd1_a : rd0_a;
    col_a[1] = s1_ctrl_r.bank_sel ? rd0_a : rd1_a;
    col_a[2] = s1_pixel_r;
    col_b[0] = s1_ctrl_r.bank_sel ? rd1_b : rd0_b;
    col_b[1] = s1_ctrl_r.bank_sel ? rd0_b : rd1_b;
    col_b[2] = s1_pixel_r;

    win_nxt[0] = win_r[1];
    if (s1_ctrl_r.is_drain) begin
      win_nxt[1] = col_b;
      win_nxt[2] = col_a;
    end else begin
      win_nxt[1] = win_r[2];
      win_nxt[2] = col_a;
    end

    min_a = is_local_min(win_nxt[0], win_nxt[1], win_nxt[2], s1_ctrl_r.lv_a,
                         s1_ctrl_r.rv_a, s1_ctrl_r.tv, s1_ctrl_r.bv_a);
    min_b = is_local_min(win_nxt[1], win_nxt[2], win_nxt[2], s1_ctrl_r.lv_b,
                         1'b0, s1_ctrl_r.tv, 1'b1);

    push_a           = s1_valid_r && s1_ctrl_r.emit_a;
    res_a.pixel_out  = min_a ? '0 : win_nxt[1][1];
    res_a.is_minimum = min_a;
    res_a.out_row    = s1_ctrl_r.row_o;
    res_a.out_column = s1_ctrl_r.col_a;
    res_a.frame_last = s1_ctrl_r.last;

    push_b           = s1_valid_r && s1_ctrl_r.emit_b;
    res_b.pixel_out  = min_b ? '0 : win_nxt[2][1];
    res_b.is_minimum = min_b;
    res_b.out_row    = s1_ctrl_r.row_o;
    res_b.out_column = s1_ctrl_r.col_b;
    res_b.frame_last = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_ctrl_r  <= s0_ctrl;
    s1_pixel_r <= s0_pixel;
    if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

endmodule

// File: hdl/lms_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on lms_pkg.
module lms_out_fifo
  import lms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_a,
  input  out_item_t res_a,
  input  logic      push_b,
  input  out_item_t res_b,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic      almost_full
);

  localparam int PW = $clog2(FIFO_DEPTH);

  out_item_t     mem_r [FIFO_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [PW:0]   count_r;
  logic [PW:0]   count_nxt;
  logic [1:0]    n_push;
  logic          pop;
  out_item_t     first;

  always_comb begin
    pop         = out_valid && !out_stall;
    n_push      = {1'b0, push_a} + {1'b0, push_b};
    count_nxt   = count_r + (PW+1)'(n_push) - (PW+1)'(pop);
    wr_ptr_nxt  = wr_ptr_r + PW'(n_push);
    rd_ptr_nxt  = rd_ptr_r + PW'(pop);
    first       = push_a ? res_a : res_b;
    out_valid   = (count_r != '0);
    out_data    = mem_r[rd_ptr_r];
    // Room must remain for the item in the window stage and one more item.
    almost_full = (count_r > (PW+1)'(FIFO_DEPTH - 4));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_a || push_b) begin
      mem_r[wr_ptr_r] <= first;
    end
    if (push_a && push_b) begin
      mem_r[wr_ptr_r + PW'(1)] <= res_b;
    end
  end

endmodule

// File: hdl/local_minimum_suppress_3x3_top.sv
// Top level of the 3x3 strict local minimum suppressor: frame counters,
// configuration registers and line buffer control.
// Depends on lms_pkg, lms_line_ram, lms_window and lms_out_fifo.
//
// Usage. Pixels enter in raster order on the in_ channel (in_valid, in_stall,
// in_data); a transfer happens at a clock edge with in_valid high and in_stall
// low. A pixel strictly below all of its in-image 8-neighbors comes out as zero
// with is_minimum set, others pass as they are. Results lag one image row. Once
// the last pixel of a frame is in, the host sends image_width drain items
// (drain = 1), each flushing one pixel of the last row; the final one carries
// frame_last. Drain items outside a flush and pixels during a flush are dropped.
// Throughput is one item per cycle while in_stall is low. At the transfer edge the
// line buffers are read and the window stage registers the item; the window stage
// then writes the results into the eight-entry result queue behind the out_ channel.
// The last pixel of each row but the first causes two results (one if the width
// is 1). When out_stall holds the queue, in_stall rises once more than four
// results are waiting, so nothing is lost. cfg_valid/cfg_ready writes image_width
// (index 0) or image_height (index 1), clamped, and restarts the frame; write only
// while idle. Reset sets both to 1024 (width at most MAX_WIDTH), empties the queue
// and starts a new frame; line buffers are not cleared.
module local_minimum_suppress_3x3_top
  import lms_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int WW      = $clog2(MAX_WIDTH + 1);
  localparam int W_RESET = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;

  // Configuration and frame position.
  logic [WW-1:0]            width_r;
  logic [WW-1:0]            width_nxt;
  logic [CFG_DATA_BITS-1:0] height_r;
  logic [CFG_DATA_BITS-1:0] height_nxt;
  logic [ROW_BITS-1:0]      row_r;
  logic [ROW_BITS-1:0]      row_nxt;
  logic [AW-1:0]            col_r;
  logic [AW-1:0]            col_nxt;
  logic [AW-1:0]            drain_cnt_r;
  logic [AW-1:0]            drain_cnt_nxt;
  logic                     flushing_r;
  logic                     flushing_nxt;
  logic                     bank_sel_r;
  logic                     bank_sel_nxt;

  logic        accept;
  logic        cfg_we;
  logic        col_last;
  logic        row_last;
  logic        drain_last;
  logic        s0_valid;
  stage_ctrl_t s0_ctrl;
  logic        ram_we;
  logic [AW-1:0] raddr_a;
  logic [AW-1:0] raddr_b;
  pix_t        rd0_a;
  pix_t        rd0_b;
  pix_t        rd1_a;
  pix_t        rd1_b;
  logic        push_a;
  logic        push_b;
  out_item_t   res_a;
  out_item_t   res_b;
  logic        almost_full;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = almost_full;
  assign accept    = in_valid && !in_stall;

  // Pixel at column c reads both banks at c; a drain tick for column d reads
  // d + 1 on port A and d on port B.
  assign raddr_a = in_data.drain ? (drain_cnt_r + AW'(1)) : col_r;
  assign raddr_b = drain_cnt_r;

  always_comb begin
    width_nxt     = width_r;
    height_nxt    = height_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    drain_cnt_nxt = drain_cnt_r;
    flushing_nxt  = flushing_r;
    bank_sel_nxt  = bank_sel_r;
    s0_valid      = 1'b0;
    s0_ctrl       = '0;
    ram_we        = 1'b0;

    col_last   = (WW'(col_r) + WW'(1) == width_r);
    row_last   = (CFG_DATA_BITS'(row_r) + CFG_DATA_BITS'(1) >= height_r);
    drain_last = (WW'(drain_cnt_r) + WW'(1) == width_r);

    s0_ctrl.bank_sel = bank_sel_r;

    if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          if (cfg_wdata == '0) begin
            width_nxt = WW'(1);
          end else if (32'(cfg_wdata) > MAX_WIDTH) begin
            width_nxt = WW'(MAX_WIDTH);
          end else begin
            width_nxt = WW'(cfg_wdata);
          end
        end
        REG_IMAGE_HEIGHT: begin
          if (cfg_wdata == '0) begin
            height_nxt = CFG_DATA_BITS'(1);
          end else if (32'(cfg_wdata) > HEIGHT_LIMIT) begin
            height_nxt = CFG_DATA_BITS'(HEIGHT_LIMIT);
          end else begin
            height_nxt = cfg_wdata;
          end
        end
        default: begin
        end
      endcase
      row_nxt       = '0;
      col_nxt       = '0;
      drain_cnt_nxt = '0;
      flushing_nxt  = 1'b0;
    end else if (accept) begin
      if (in_data.drain) begin
        if (flushing_r && (WW'(drain_cnt_r) < width_r)) begin
          s0_valid         = 1'b1;
          s0_ctrl.is_drain = 1'b1;
          s0_ctrl.emit_a   = 1'b1;
          s0_ctrl.lv_a     = (drain_cnt_r != '0);
          s0_ctrl.rv_a     = !drain_last;
          s0_ctrl.bv_a     = 1'b0;
          s0_ctrl.tv       = (height_r > CFG_DATA_BITS'(1));
          s0_ctrl.last     = drain_last;
          s0_ctrl.row_o    = ROW_BITS'(height_r - CFG_DATA_BITS'(1));
          s0_ctrl.col_a    = COL_BITS'(drain_cnt_r);
          if (drain_last) begin
            row_nxt       = '0;
            col_nxt       = '0;
            drain_cnt_nxt = '0;
            flushing_nxt  = 1'b0;
          end else begin
            drain_cnt_nxt = drain_cnt_r + AW'(1);
          end
        end
      end else if (!flushing_r) begin
        s0_valid       = 1'b1;
        ram_we         = 1'b1;
        s0_ctrl.emit_a = (row_r != '0) && (col_r != '0);
        s0_ctrl.emit_b = (row_r != '0) && col_last;
        s0_ctrl.lv_a   = (col_r > AW'(1));
        s0_ctrl.rv_a   = 1'b1;
        s0_ctrl.bv_a   = 1'b1;
        s0_ctrl.lv_b   = (col_r != '0);
        s0_ctrl.tv     = (row_r > ROW_BITS'(1));
        s0_ctrl.row_o  = row_r - ROW_BITS'(1);
        s0_ctrl.col_a  = COL_BITS'(col_r - AW'(1));
        s0_ctrl.col_b  = COL_BITS'(col_r);
        if (col_last) begin
          // The row just written becomes the middle row; the old middle row
          // becomes the upper row that the next row overwrites.
          col_nxt      = '0;
          bank_sel_nxt = !bank_sel_r;
          if (row_last) begin
            flushing_nxt  = 1'b1;
            drain_cnt_nxt = '0;
          end else begin
            row_nxt = row_r + ROW_BITS'(1);
          end
        end else begin
          col_nxt = col_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= WW'(W_RESET);
      height_r    <= CFG_DATA_BITS'(HEIGHT_LIMIT);
      row_r       <= '0;
      col_r       <= '0;
      drain_cnt_r <= '0;
      flushing_r  <= 1'b0;
      bank_sel_r  <= 1'b0;
    end else begin
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      flushing_r  <= flushing_nxt;
      bank_sel_r  <= bank_sel_nxt;
    end
  end

  // Two line banks; the pixel always overwrites the upper-row bank.
  lms_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_bank0 (
    .clk     (clk),
    .we      (ram_we && !bank_sel_r),
    .waddr   (col_r),
    .wdata   (in_data.pixel_in),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd0_a),
    .rdata_b (rd0_b)
  );

  lms_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW),
    .DW    (PIXEL_BITS)
  ) u_bank1 (
    .clk     (clk),
    .we      (ram_we && bank_sel_r),
    .waddr   (col_r),
    .wdata   (in_data.pixel_in),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rd1_a),
    .rdata_b (rd1_b)
  );

  lms_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .s0_valid (s0_valid),
    .s0_ctrl  (s0_ctrl),
    .s0_pixel (in_data.pixel_in),
    .rd0_a    (rd0_a),
    .rd0_b    (rd0_b),
    .rd1_a    (rd1_a),
    .rd1_b    (rd1_b),
    .push_a   (push_a),
    .res_a    (res_a),
    .push_b   (push_b),
    .res_b    (res_b)
  );

  lms_out_fifo u_out_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_a      (push_a),
    .res_a       (res_a),
    .push_b      (push_b),
    .res_b       (res_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .almost_full (almost_full)
  );

endmodule
